/* hw/rtl/box_blur_3x3_stream_top_assert.svh */
// Assertion macros for the 3x3 box blur stream checker.
`ifndef BOX_BLUR_3X3_STREAM_TOP_ASSERT_SVH
`define BOX_BLUR_3X3_STREAM_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BB3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define BB3_ASSERT_RESET(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/bb3_pkg.sv */
// Shared types and constants of the 3x3 box blur stream.
package bb3_pkg;

    localparam int DEF_MAX_LINE  = 1024;
    localparam int PIX_W         = 8;
    localparam int RGB_W         = 3 * PIX_W;
    localparam int LINE_W        = 2 * RGB_W;
    localparam int ROW_W         = 12;
    localparam int FW_W          = 11;
    localparam int FH_W          = 12;
    localparam int SUM_W         = 12;
    localparam int N_W           = 4;
    localparam int WIN           = 3;
    localparam int NSLOT         = 4;
    localparam int APB_W         = 32;
    localparam int PADDR_W       = 3;
    localparam int REG_IDX_BIT   = 2;

    localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
    localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sums;

    typedef struct packed {
        logic row_ge1;
        logic row_ge2;
        logic col_ge1;
        logic col_ge2;
        logic last_row;
        logic last_col;
    } t_pos;

    typedef struct packed {
        logic run_last;
        logic frame_end;
    } t_tag;

endpackage

/* hw/rtl/box_blur_3x3_stream_top.sv */
// Top level of the 3x3 box blur over an RGB raster pixel stream.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_ready    i_in_red, i_in_green, i_in_blue
//   out      source     o_out_valid / i_out_ready  o_out_row, o_out_col, o_out_red,
//                                                  o_out_green, o_out_blue,
//                                                  o_run_last, o_frame_end
//   cfg      APB slave  psel / penable / pready    paddr, pwrite, pwdata, prdata
//
// One pixel per cycle unless the output stalls or a pixel holds the input.
// Results go through the sum and mean stages one per cycle unless the output stalls,
// so a pixel with k results (row end, last row) holds input until k-1 are issued.
// Synchronous reset clears control only; the line store needs no clearing pass.
// Output stalls back up through the pipeline to o_in_ready.
module box_blur_3x3_stream_top import bb3_pkg::*; #(
    parameter int MAX_LINE = DEF_MAX_LINE,
    localparam int COL_W = $clog2(MAX_LINE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [PIX_W-1:0]   i_in_red,
    input  logic [PIX_W-1:0]   i_in_green,
    input  logic [PIX_W-1:0]   i_in_blue,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [ROW_W-1:0]   o_out_row,
    output logic [COL_W-1:0]   o_out_col,
    output logic [PIX_W-1:0]   o_out_red,
    output logic [PIX_W-1:0]   o_out_green,
    output logic [PIX_W-1:0]   o_out_blue,
    output logic               o_run_last,
    output logic               o_frame_end,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    logic             restart;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] last_row;
    t_rgb             in_px;

    logic             s1_valid, s1_take;
    t_rgb             s1_px, s1_above2, s1_above1;
    logic [ROW_W-1:0] s1_row;
    logic [COL_W-1:0] s1_col;
    t_pos             s1_pos;

    logic             sm_valid, sm_ready;
    t_sums            sm_sums;
    logic [N_W-1:0]   sm_cnt;
    logic [ROW_W-1:0] sm_row;
    logic [COL_W-1:0] sm_col;
    t_tag             sm_tag;

    assign pready = 1'b1;
    assign in_px  = '{red: i_in_red, green: i_in_green, blue: i_in_blue};

    bb3_cfg #(.MAX_LINE(MAX_LINE)) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .o_restart  (restart),
        .o_last_col (last_col),
        .o_last_row (last_row)
    );

    bb3_line #(.MAX_LINE(MAX_LINE)) u_line (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_last_col (last_col),
        .i_last_row (last_row),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_px       (in_px),
        .i_take     (s1_take),
        .o_valid    (s1_valid),
        .o_px       (s1_px),
        .o_above2   (s1_above2),
        .o_above1   (s1_above1),
        .o_row      (s1_row),
        .o_col      (s1_col),
        .o_pos      (s1_pos)
    );

    bb3_win #(.MAX_LINE(MAX_LINE)) u_win (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s1_valid),
        .o_take   (s1_take),
        .i_px     (s1_px),
        .i_above2 (s1_above2),
        .i_above1 (s1_above1),
        .i_row    (s1_row),
        .i_col    (s1_col),
        .i_pos    (s1_pos),
        .i_ready  (sm_ready),
        .o_valid  (sm_valid),
        .o_sums   (sm_sums),
        .o_cnt    (sm_cnt),
        .o_row    (sm_row),
        .o_col    (sm_col),
        .o_tag    (sm_tag)
    );

    bb3_div #(.MAX_LINE(MAX_LINE)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (sm_valid),
        .o_ready     (sm_ready),
        .i_sums      (sm_sums),
        .i_cnt       (sm_cnt),
        .i_row       (sm_row),
        .i_col       (sm_col),
        .i_tag       (sm_tag),
        .i_ready     (i_out_ready),
        .o_valid     (o_out_valid),
        .o_row       (o_out_row),
        .o_col       (o_out_col),
        .o_red       (o_out_red),
        .o_green     (o_out_green),
        .o_blue      (o_out_blue),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end)
    );

endmodule

/* hw/rtl/bb3_cfg.sv */
// APB register file: frame width and height, effective last column and row.
module bb3_cfg import bb3_pkg::*; #(
    parameter int MAX_LINE = DEF_MAX_LINE,
    localparam int COL_W = $clog2(MAX_LINE)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               o_restart,
    output logic [COL_W-1:0]   o_last_col,
    output logic [ROW_W-1:0]   o_last_row
);

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic            wr_en;
    t_reg_idx        reg_idx;

    assign wr_en     = psel && penable && pwrite;
    assign reg_idx   = t_reg_idx'(paddr[REG_IDX_BIT]);
    assign o_restart = wr_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH:  r_frame_width  <= pwdata[FW_W-1:0];
                REG_HEIGHT: r_frame_height <= pwdata[FH_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = APB_W'(r_frame_width);
            REG_HEIGHT: prdata = APB_W'(r_frame_height);
        endcase
    end

    always_comb begin
        priority if (r_frame_width == '0) begin
            o_last_col = '0;
        end else if (32'(r_frame_width) > MAX_LINE) begin
            o_last_col = COL_W'(MAX_LINE - 1);
        end else begin
            o_last_col = COL_W'(r_frame_width - 1'b1);
        end
    end

    assign o_last_row = (r_frame_height == '0) ? '0 : ROW_W'(r_frame_height - 1'b1);

endmodule

/* hw/rtl/bb3_line.sv */
// Input stage: raster counters, two-row line store and its read register.
module bb3_line import bb3_pkg::*; #(
    parameter int MAX_LINE = DEF_MAX_LINE,
    localparam int COL_W = $clog2(MAX_LINE)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  logic [COL_W-1:0] i_last_col,
    input  logic [ROW_W-1:0] i_last_row,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_rgb             i_px,
    input  logic             i_take,
    output logic             o_valid,
    output t_rgb             o_px,
    output t_rgb             o_above2,
    output t_rgb             o_above1,
    output logic [ROW_W-1:0] o_row,
    output logic [COL_W-1:0] o_col,
    output t_pos             o_pos
);

    logic [COL_W-1:0]  r_col, n_col, r_c;
    logic [ROW_W-1:0]  r_row, n_row, r_r;
    logic              r_v;
    t_rgb              r_px;
    t_pos              r_pos;
    logic [LINE_W-1:0] r_rd;
    logic              r_fwd;
    logic [LINE_W-1:0] r_fwd_data;
    logic [LINE_W-1:0] rd_eff;
    logic [LINE_W-1:0] wr_data;
    logic              accept;
    logic [LINE_W-1:0] r_mem [MAX_LINE];

    assign o_ready = !r_v || i_take;
    assign accept  = i_valid && o_ready;

    // a store write and a read of the same column in one cycle bypass the memory
    assign rd_eff   = r_fwd ? r_fwd_data : r_rd;
    assign o_above2 = rd_eff[LINE_W-1 -: RGB_W];
    assign o_above1 = rd_eff[RGB_W-1:0];
    assign wr_data  = {o_above1, r_px};

    always_comb begin
        if (r_col == i_last_col) begin
            n_col = '0;
            n_row = (r_row == i_last_row) ? '0 : r_row + 1'b1;
        end else begin
            n_col = r_col + 1'b1;
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_v   <= 1'b0;
        end else if (i_restart) begin
            r_col <= '0;
            r_row <= '0;
            r_v   <= 1'b0;
        end else begin
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
                r_v   <= 1'b1;
            end else if (i_take) begin
                r_v   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px           <= i_px;
            r_c            <= r_col;
            r_r            <= r_row;
            r_pos.row_ge1  <= (r_row != '0);
            r_pos.row_ge2  <= (r_row > ROW_W'(1));
            r_pos.col_ge1  <= (r_col != '0);
            r_pos.col_ge2  <= (r_col > COL_W'(1));
            r_pos.last_row <= (r_row == i_last_row);
            r_pos.last_col <= (r_col == i_last_col);
            r_fwd          <= i_take && (r_col == r_c);
            r_fwd_data     <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_mem[r_col];
        end
        if (i_take) begin
            r_mem[r_c] <= wr_data;
        end
    end

    assign o_valid = r_v;
    assign o_px    = r_px;
    assign o_row   = r_r;
    assign o_col   = r_c;
    assign o_pos   = r_pos;

endmodule

/* hw/rtl/bb3_win.sv */
// 3x3 window registers, result sequencer and masked neighborhood sums.
module bb3_win import bb3_pkg::*; #(
    parameter int MAX_LINE = DEF_MAX_LINE,
    localparam int COL_W = $clog2(MAX_LINE)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_take,
    input  t_rgb             i_px,
    input  t_rgb             i_above2,
    input  t_rgb             i_above1,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    input  t_pos             i_pos,
    input  logic             i_ready,
    output logic             o_valid,
    output t_sums            o_sums,
    output logic [N_W-1:0]   o_cnt,
    output logic [ROW_W-1:0] o_row,
    output logic [COL_W-1:0] o_col,
    output t_tag             o_tag
);

    // upper row left/center, lower row left/center
    typedef enum logic [1:0] {
        SLOT_UL = 2'd0,
        SLOT_UC = 2'd1,
        SLOT_LL = 2'd2,
        SLOT_LC = 2'd3
    } t_slot;

    t_rgb             r_win [WIN][WIN];
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    t_pos             r_pos;
    logic [NSLOT-1:0] r_pend;
    logic             r_sv;
    t_sums            r_sums;
    logic [N_W-1:0]   r_cnt;
    logic [ROW_W-1:0] r_orow;
    logic [COL_W-1:0] r_ocol;
    t_tag             r_tag;

    t_slot            sel;
    logic             sum_load, issue, win_free, up, left;
    logic [NSLOT-1:0] pend_rest, new_pend;
    logic [WIN-1:0]   rmask, cmask;
    t_sums            n_sums;
    logic [N_W-1:0]   n_cnt;
    t_tag             n_tag;

    always_comb begin
        priority if (r_pend[SLOT_UL]) sel = SLOT_UL;
        else if (r_pend[SLOT_UC])     sel = SLOT_UC;
        else if (r_pend[SLOT_LL])     sel = SLOT_LL;
        else                          sel = SLOT_LC;
    end

    assign sum_load  = !r_sv || i_ready;
    assign issue     = (r_pend != '0) && sum_load;
    assign pend_rest = r_pend & ~(NSLOT'(1) << sel);
    assign win_free  = (r_pend == '0) || (issue && (pend_rest == '0));
    assign o_take    = i_valid && win_free;

    assign new_pend[SLOT_UL] = i_pos.row_ge1  && i_pos.col_ge1;
    assign new_pend[SLOT_UC] = i_pos.row_ge1  && i_pos.last_col;
    assign new_pend[SLOT_LL] = i_pos.last_row && i_pos.col_ge1;
    assign new_pend[SLOT_LC] = i_pos.last_row && i_pos.last_col;

    assign up   = (sel == SLOT_UL) || (sel == SLOT_UC);
    assign left = (sel == SLOT_UL) || (sel == SLOT_LL);

    // window row 0 is two rows up, column 0 is two columns back
    always_comb begin
        rmask = up   ? {1'b1, 1'b1, r_pos.row_ge2} : {1'b1, r_pos.row_ge1, 1'b0};
        cmask = left ? {1'b1, 1'b1, r_pos.col_ge2} : {1'b1, r_pos.col_ge1, 1'b0};
        n_sums = '0;
        for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN; j++) begin
                if (rmask[i] && cmask[j]) begin
                    n_sums.red   += SUM_W'(r_win[i][j].red);
                    n_sums.green += SUM_W'(r_win[i][j].green);
                    n_sums.blue  += SUM_W'(r_win[i][j].blue);
                end
            end
        end
        n_cnt = N_W'($countones(rmask)) * N_W'($countones(cmask));
        n_tag.run_last  = (pend_rest == '0);
        n_tag.frame_end = (pend_rest == '0) && r_pos.last_row && r_pos.last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_sv   <= 1'b0;
        end else begin
            if (o_take) begin
                r_pend <= new_pend;
            end else if (issue) begin
                r_pend <= pend_rest;
            end
            if (issue) begin
                r_sv <= 1'b1;
            end else if (i_ready) begin
                r_sv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            for (int i = 0; i < WIN; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= i_above2;
            r_win[1][2] <= i_above1;
            r_win[2][2] <= i_px;
            r_row       <= i_row;
            r_col       <= i_col;
            r_pos       <= i_pos;
        end
        if (issue) begin
            r_sums <= n_sums;
            r_cnt  <= n_cnt;
            r_orow <= up ? r_row - 1'b1 : r_row;
            r_ocol <= left ? r_col - 1'b1 : r_col;
            r_tag  <= n_tag;
        end
    end

    assign o_valid = r_sv;
    assign o_sums  = r_sums;
    assign o_cnt   = r_cnt;
    assign o_row   = r_orow;
    assign o_col   = r_ocol;
    assign o_tag   = r_tag;

endmodule

/* hw/rtl/bb3_div.sv */
// Rounded mean by reciprocal multiply, and the result output register.
module bb3_div import bb3_pkg::*; #(
    parameter int MAX_LINE = DEF_MAX_LINE,
    localparam int COL_W = $clog2(MAX_LINE)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_sums            i_sums,
    input  logic [N_W-1:0]   i_cnt,
    input  logic [ROW_W-1:0] i_row,
    input  logic [COL_W-1:0] i_col,
    input  t_tag             i_tag,
    input  logic             i_ready,
    output logic             o_valid,
    output logic [ROW_W-1:0] o_row,
    output logic [COL_W-1:0] o_col,
    output logic [PIX_W-1:0] o_red,
    output logic [PIX_W-1:0] o_green,
    output logic [PIX_W-1:0] o_blue,
    output logic             o_run_last,
    output logic             o_frame_end
);

    localparam int RECIP_SHIFT = 17;
    localparam int RECIP_W     = 17;
    localparam int X_W         = SUM_W + 1;
    localparam int PROD_W      = X_W + RECIP_W;

    // ceil(2^17 / (2n)); exact for every numerator 2*sum+n this block forms
    function automatic logic [RECIP_W-1:0] recip(input logic [N_W-1:0] cnt);
        logic [RECIP_W-1:0] m;
        unique case (cnt)
            N_W'(1):  m = RECIP_W'(65536);
            N_W'(2):  m = RECIP_W'(32768);
            N_W'(3):  m = RECIP_W'(21846);
            N_W'(4):  m = RECIP_W'(16384);
            N_W'(6):  m = RECIP_W'(10923);
            N_W'(9):  m = RECIP_W'(7282);
            default:  m = '0;
        endcase
        return m;
    endfunction

    function automatic logic [PIX_W-1:0] round_mean(input logic [SUM_W-1:0] sum,
                                                    input logic [RECIP_W-1:0] m,
                                                    input logic [N_W-1:0] cnt);
        logic [X_W-1:0]    x;
        logic [PROD_W-1:0] prod;
        x    = {sum, 1'b0} + X_W'(cnt);
        prod = PROD_W'(x) * PROD_W'(m);
        return prod[RECIP_SHIFT +: PIX_W];
    endfunction

    logic               r_ov;
    logic               load;
    logic [RECIP_W-1:0] m;

    assign o_ready = !r_ov || i_ready;
    assign load    = i_valid && o_ready;
    assign m       = recip(i_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_row       <= i_row;
            o_col       <= i_col;
            o_red       <= round_mean(i_sums.red, m, i_cnt);
            o_green     <= round_mean(i_sums.green, m, i_cnt);
            o_blue      <= round_mean(i_sums.blue, m, i_cnt);
            o_run_last  <= i_tag.run_last;
            o_frame_end <= i_tag.frame_end;
        end
    end

    assign o_valid = r_ov;

endmodule

/* hw/rtl/bb3_chk.sv */
// Port-level assertion checker for the 3x3 box blur stream, bound to the top.
`include "box_blur_3x3_stream_top_assert.svh"

module bb3_chk import bb3_pkg::*; #(
    parameter int MAX_LINE = DEF_MAX_LINE,
    localparam int COL_W = $clog2(MAX_LINE)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [ROW_W-1:0] o_out_row,
    input logic [COL_W-1:0] o_out_col,
    input logic [PIX_W-1:0] o_out_red,
    input logic [PIX_W-1:0] o_out_green,
    input logic [PIX_W-1:0] o_out_blue,
    input logic             o_run_last,
    input logic             o_frame_end
);

    `BB3_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_row) && $stable(o_out_col) && $stable(o_out_red) && $stable(o_out_green) && $stable(o_out_blue) && $stable(o_run_last) && $stable(o_frame_end), "stalled result changed")
    `BB3_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n, o_out_valid && o_frame_end, o_run_last, "frame end on a result that is not the last of its transfer")
    `BB3_ASSERT_RESET(a_reset_empty, i_clk, !i_rst_n, !o_out_valid, "result valid right after reset")

endmodule

bind box_blur_3x3_stream_top bb3_chk #(.MAX_LINE(MAX_LINE)) u_bb3_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_row   (o_out_row),
    .o_out_col   (o_out_col),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue),
    .o_run_last  (o_run_last),
    .o_frame_end (o_frame_end)
);
